// ===== hw/rtl/bppc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bppc_pkg: shared types and constants for the brushless motor controller
// Holds the item layout passed from the front end to the back end, the gain
// register map, the reset values and the six-step gate tables.
// ----------------------------------------------------------------------------
package bppc_pkg;

  // Default PWM period in ticks.
  localparam int unsigned PWM_PERIOD_DEF = 100;

  // Widths fixed by the item fields.
  localparam int unsigned SPEED_W = 11;
  localparam int unsigned ERR_W   = 12;
  localparam int unsigned DERR_W  = 13;
  localparam int unsigned GAIN_W  = 32;
  localparam int unsigned ESUM_W  = 32;
  localparam int unsigned HALL_W  = 3;
  localparam int unsigned GATE_W  = 6;
  localparam int unsigned DUTY_W  = 8;
  // Carried counter width, wide enough for PWM periods up to 256.
  localparam int unsigned CNT_W   = 8;
  // Configuration index width.
  localparam int unsigned CFG_IDX_W = 2;

  // Queue between the front and back ends.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  // Gain register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 2'd2;

  // Gain reset values, unsigned Q16.16.
  localparam logic [GAIN_W-1:0] GAIN_P_RST = 32'd9830400;
  localparam logic [GAIN_W-1:0] GAIN_I_RST = 32'd13;
  localparam logic [GAIN_W-1:0] GAIN_D_RST = 32'd393216000;

  // State reset values.
  localparam logic [DUTY_W-1:0] DUTY_RST = 8'd20;
  localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

  // Hall codes that carry no rotor position.
  localparam logic [HALL_W-1:0] HALL_NONE = 3'd0;
  localparam logic [HALL_W-1:0] HALL_ALL  = 3'd7;

  // Item kinds.
  typedef enum logic {
    KIND_CTRL = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    kind_e                     kind;
    logic                      rev;
    logic                      hall_ok;
    logic [HALL_W-1:0]         hall;
    logic [CNT_W-1:0]          cnt;
    logic signed [ERR_W-1:0]   err;
    logic signed [DERR_W-1:0]  derr;
    logic signed [ESUM_W-1:0]  esum;
  } item_t;

  // Gate tables indexed by Hall code; AH,AL,BH,BL,CH,CL from bit 5 down.
  localparam logic [GATE_W-1:0] ON_FWD [8] =
    '{6'h00, 6'h24, 6'h12, 6'h06, 6'h09, 6'h21, 6'h18, 6'h00};
  localparam logic [GATE_W-1:0] ON_REV [8] =
    '{6'h00, 6'h18, 6'h21, 6'h09, 6'h06, 6'h12, 6'h24, 6'h00};
  localparam logic [GATE_W-1:0] OFF_FWD [8] =
    '{6'h00, 6'h04, 6'h02, 6'h02, 6'h01, 6'h20, 6'h08, 6'h00};
  localparam logic [GATE_W-1:0] OFF_REV [8] =
    '{6'h00, 6'h08, 6'h01, 6'h01, 6'h02, 6'h02, 6'h04, 6'h00};

  // Select the gate pattern for a direction, PWM phase and Hall code.
  function automatic logic [GATE_W-1:0] gate_lookup(logic dir, logic phase_on,
                                                    logic [HALL_W-1:0] hall);
    logic [GATE_W-1:0] res;
    if (phase_on) begin
      res = dir ? ON_REV[hall] : ON_FWD[hall];
    end else begin
      res = dir ? OFF_REV[hall] : OFF_FWD[hall];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bldc_pid_pwm_commutator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bldc_pid_pwm_commutator_unit: brushless motor speed controller
// PID speed loop in Q16.16 setting duty and direction, and six-step
// commutation driving the gate bits from the Hall code on each PWM tick.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+------------------------------------
//  input    | in_valid_i / in_ready_o    | kind, speeds, reverse_mode, hall
//  output   | out_valid_o / out_ready_i  | gate_bits, duty, direction
//  config   | cfg_we_i (no wait)         | cfg_idx_i, cfg_wdata_i
//
// One item per cycle is sustained while the output is not stalled; each result
// passes the queue and then the multiply, clamp, sum and commit stages.
// A four-entry queue lets intake continue while the output is stalled.
// Reset clears the control state but loads the duty and gain reset values;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module bldc_pid_pwm_commutator_unit #(
  parameter int unsigned PWM_PERIOD = bppc_pkg::PWM_PERIOD_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                kind_i,
  input  wire logic signed [bppc_pkg::SPEED_W-1:0] target_speed_i,
  input  wire logic signed [bppc_pkg::SPEED_W-1:0] measured_speed_i,
  input  wire logic                                reverse_mode_i,
  input  wire logic [bppc_pkg::HALL_W-1:0]         hall_code_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [bppc_pkg::GATE_W-1:0]              gate_bits_o,
  output logic [bppc_pkg::DUTY_W-1:0]              duty_o,
  output logic                                     direction_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [bppc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [bppc_pkg::GAIN_W-1:0]         cfg_wdata_i
);

  logic [bppc_pkg::GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic                        q_full, q_valid, q_pop, in_acc;
  bppc_pkg::item_t             push_item, pop_item;

  // Gain registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= bppc_pkg::GAIN_P_RST;
      gain_i_q <= bppc_pkg::GAIN_I_RST;
      gain_d_q <= bppc_pkg::GAIN_D_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bppc_pkg::REG_GAIN_P: gain_p_q <= cfg_wdata_i;
        bppc_pkg::REG_GAIN_I: gain_i_q <= cfg_wdata_i;
        bppc_pkg::REG_GAIN_D: gain_d_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !q_full;
  assign in_acc     = in_valid_i && !q_full;

  // Front end: intake and classification.
  bppc_front #(
    .PWM_PERIOD(PWM_PERIOD)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .acc_i           (in_acc),
    .kind_i          (kind_i),
    .target_speed_i  (target_speed_i),
    .measured_speed_i(measured_speed_i),
    .reverse_mode_i  (reverse_mode_i),
    .hall_code_i     (hall_code_i),
    .item_o          (push_item)
  );

  // Queue between the two ends.
  bppc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_acc),
    .push_item_i(push_item),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_item_o (pop_item)
  );

  // Back end: PID arithmetic and gate drive.
  bppc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .gain_p_i   (gain_p_q),
    .gain_i_i   (gain_i_q),
    .gain_d_i   (gain_d_q),
    .q_valid_i  (q_valid),
    .q_item_i   (pop_item),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .gate_bits_o(gate_bits_o),
    .duty_o     (duty_o),
    .direction_o(direction_o)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/bppc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bppc_front: item intake and classification
// Accepts items, keeps the error integral, last error and PWM counter, and
// turns each item into a classified entry for the queue.
// ----------------------------------------------------------------------------
module bppc_front #(
  parameter int unsigned PWM_PERIOD = bppc_pkg::PWM_PERIOD_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                acc_i,
  input  wire logic                                kind_i,
  input  wire logic signed [bppc_pkg::SPEED_W-1:0] target_speed_i,
  input  wire logic signed [bppc_pkg::SPEED_W-1:0] measured_speed_i,
  input  wire logic                                reverse_mode_i,
  input  wire logic [bppc_pkg::HALL_W-1:0]         hall_code_i,
  output bppc_pkg::item_t                          item_o
);

  localparam int unsigned CW = (PWM_PERIOD > 1) ? $clog2(PWM_PERIOD) : 1;
  localparam logic [CW-1:0] CNT_LAST = CW'(PWM_PERIOD - 1);

  logic [CW-1:0]                           cnt_q, cnt_d, cnt_next;
  logic signed [bppc_pkg::ESUM_W-1:0]      esum_q, esum_d, esum_next;
  logic signed [bppc_pkg::ERR_W-1:0]       perr_q, perr_d;
  logic signed [bppc_pkg::ERR_W-1:0]       err;
  logic signed [bppc_pkg::DERR_W-1:0]      derr;
  logic signed [bppc_pkg::ESUM_W:0]        esum_wide;
  logic                                    is_tick;

  assign is_tick = (bppc_pkg::kind_e'(kind_i) == bppc_pkg::KIND_TICK);

  // Speed error and its change since the last control item.
  assign err  = bppc_pkg::ERR_W'(target_speed_i) - bppc_pkg::ERR_W'(measured_speed_i);
  assign derr = bppc_pkg::DERR_W'(err) - bppc_pkg::DERR_W'(perr_q);

  // Saturating integral of the error.
  assign esum_wide = (bppc_pkg::ESUM_W + 1)'(esum_q) + (bppc_pkg::ESUM_W + 1)'(err);
  always_comb begin
    if (esum_wide[bppc_pkg::ESUM_W] != esum_wide[bppc_pkg::ESUM_W-1]) begin
      esum_next = esum_wide[bppc_pkg::ESUM_W] ? {1'b1, {(bppc_pkg::ESUM_W-1){1'b0}}}
                                               : {1'b0, {(bppc_pkg::ESUM_W-1){1'b1}}};
    end else begin
      esum_next = esum_wide[bppc_pkg::ESUM_W-1:0];
    end
  end

  // PWM counter wraps at the period.
  assign cnt_next = (cnt_q == CNT_LAST) ? '0 : CW'(cnt_q + 1'b1);

  // State updates happen when an item is accepted.
  always_comb begin
    cnt_d  = cnt_q;
    esum_d = esum_q;
    perr_d = perr_q;
    if (acc_i) begin
      if (is_tick) begin
        cnt_d = cnt_next;
      end else begin
        esum_d = esum_next;
        perr_d = err;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      esum_q <= '0;
      perr_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      esum_q <= esum_d;
      perr_q <= perr_d;
    end
  end

  // Classified entry for the back end.
  always_comb begin
    item_o.kind    = bppc_pkg::kind_e'(kind_i);
    item_o.rev     = reverse_mode_i;
    item_o.hall_ok = (hall_code_i != bppc_pkg::HALL_NONE) &&
                     (hall_code_i != bppc_pkg::HALL_ALL);
    item_o.hall    = hall_code_i;
    item_o.cnt     = bppc_pkg::CNT_W'(cnt_next);
    item_o.err     = err;
    item_o.derr    = derr;
    item_o.esum    = esum_next;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bppc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bppc_queue: short item queue
// Decouples the front end from the back end so each side stalls on its own.
// ----------------------------------------------------------------------------
module bppc_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire bppc_pkg::item_t push_item_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output bppc_pkg::item_t      pop_item_o
);

  localparam int unsigned CNT_BITS = $clog2(bppc_pkg::QDEPTH + 1);

  bppc_pkg::item_t                 entry_q [bppc_pkg::QDEPTH];
  logic [bppc_pkg::QPTR_W-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_BITS-1:0]             count_q, count_d;

  assign full_o     = (count_q == CNT_BITS'(bppc_pkg::QDEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_item_o = entry_q[rptr_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wptr_d  = push_i ? bppc_pkg::QPTR_W'(wptr_q + 1'b1) : wptr_q;
    rptr_d  = pop_i ? bppc_pkg::QPTR_W'(rptr_q + 1'b1) : rptr_q;
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = CNT_BITS'(count_q + 1'b1);
    end else if (pop_i && !push_i) begin
      count_d = CNT_BITS'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bppc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bppc_back: PID arithmetic and gate drive
// Four in-order stages: gain products, integral clamp with partial sum,
// full sum, and commit of duty, direction and gate bits to the output.
// ----------------------------------------------------------------------------
module bppc_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [bppc_pkg::GAIN_W-1:0]       gain_p_i,
  input  wire logic [bppc_pkg::GAIN_W-1:0]       gain_i_i,
  input  wire logic [bppc_pkg::GAIN_W-1:0]       gain_d_i,
  input  wire logic                              q_valid_i,
  input  wire bppc_pkg::item_t                   q_item_i,
  output logic                                   q_pop_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [bppc_pkg::GATE_W-1:0]            gate_bits_o,
  output logic [bppc_pkg::DUTY_W-1:0]            duty_o,
  output logic                                   direction_o
);

  localparam int unsigned PP_W  = bppc_pkg::GAIN_W + 1 + bppc_pkg::ERR_W;
  localparam int unsigned PD_W  = bppc_pkg::GAIN_W + 1 + bppc_pkg::DERR_W;
  localparam int unsigned SUM_W = 64;
  localparam int unsigned PDS_W = PD_W + 1;
  localparam logic signed [SUM_W-1:0] LIM_POS = 64'sh4000_0000_0000_0000;
  localparam logic signed [SUM_W-1:0] LIM_NEG = -64'sh4000_0000_0000_0000;

  // Tag carried alongside the arithmetic.
  typedef struct packed {
    bppc_pkg::kind_e              kind;
    logic                         rev;
    logic                         hall_ok;
    logic [bppc_pkg::HALL_W-1:0]  hall;
    logic [bppc_pkg::CNT_W-1:0]   cnt;
  } tag_t;

  logic                     adv;
  tag_t                     tag0;
  logic                     v1_q, v2_q, v3_q, out_valid_q;
  tag_t                     tag1_q, tag2_q, tag3_q;
  logic signed [PP_W-1:0]   prod_p_q;
  logic signed [PD_W-1:0]   prod_d_q;
  logic signed [SUM_W-1:0]  prod_i_q;
  logic signed [SUM_W-1:0]  ipc_q, ipc_d;
  logic signed [PDS_W-1:0]  pd_q;
  logic signed [SUM_W-1:0]  out_q;
  logic signed [bppc_pkg::GAIN_W:0] gp_s, gi_s, gd_s;
  logic [SUM_W-1:0]         mag;
  logic                     neg;
  logic [bppc_pkg::DUTY_W-1:0] duty_q, duty_d;
  logic                     dir_q, dir_d;
  logic [bppc_pkg::GATE_W-1:0] gate_q, gate_d;
  logic                     commit;

  // The whole pipe moves when the output slot is free or being taken.
  assign adv     = !out_valid_q || out_ready_i;
  assign q_pop_o = adv && q_valid_i;
  assign commit  = adv && v3_q;

  assign tag0.kind    = q_item_i.kind;
  assign tag0.rev     = q_item_i.rev;
  assign tag0.hall_ok = q_item_i.hall_ok;
  assign tag0.hall    = q_item_i.hall;
  assign tag0.cnt     = q_item_i.cnt;

  assign gp_s = $signed({1'b0, gain_p_i});
  assign gi_s = $signed({1'b0, gain_i_i});
  assign gd_s = $signed({1'b0, gain_d_i});

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= q_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage 1: the three gain products.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      tag1_q   <= tag0;
      prod_p_q <= gp_s * q_item_i.err;
      prod_d_q <= gd_s * q_item_i.derr;
      prod_i_q <= gi_s * q_item_i.esum;
    end
  end

  // Stage 2: clamp the integral term and add the other two.
  always_comb begin
    if (prod_i_q > LIM_POS) begin
      ipc_d = LIM_POS;
    end else if (prod_i_q < LIM_NEG) begin
      ipc_d = LIM_NEG;
    end else begin
      ipc_d = prod_i_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tag2_q <= tag1_q;
      ipc_q  <= ipc_d;
      pd_q   <= PDS_W'(prod_p_q) + PDS_W'(prod_d_q);
    end
  end

  // Stage 3: full controller output.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      tag3_q <= tag2_q;
      out_q  <= ipc_q + SUM_W'(pd_q);
    end
  end

  // Stage 4: magnitude, saturation and gate selection.
  assign neg = out_q[SUM_W-1];
  assign mag = neg ? SUM_W'(-out_q) : SUM_W'(out_q);

  always_comb begin
    duty_d = duty_q;
    dir_d  = dir_q;
    gate_d = gate_q;
    if (commit) begin
      if (tag3_q.kind == bppc_pkg::KIND_TICK) begin
        if (tag3_q.hall_ok) begin
          gate_d = bppc_pkg::gate_lookup(dir_q, (tag3_q.cnt <= duty_q), tag3_q.hall);
        end
      end else begin
        duty_d = (|mag[SUM_W-1:24]) ? bppc_pkg::DUTY_MAX : mag[23:16];
        dir_d  = neg ^ tag3_q.rev;
      end
    end
  end

  // Controller state doubles as the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q      <= bppc_pkg::DUTY_RST;
      dir_q       <= 1'b0;
      gate_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      duty_q <= duty_d;
      dir_q  <= dir_d;
      gate_q <= gate_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign gate_bits_o = gate_q;
  assign duty_o      = duty_q;
  assign direction_o = dir_q;

endmodule
`default_nettype wire

// ===== sim/bldc_pid_pwm_commutator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bldc_pid_pwm_commutator_unit_tb: self-checking bench for the motor controller
// Streams control updates and PWM ticks through the valid/ready channels,
// mirrors the PID speed loop and the six-step commutation in a local model,
// and compares every result field by field against the oldest prediction.
// Gains are rewritten between phases while the block is drained.
// ----------------------------------------------------------------------------
module bldc_pid_pwm_commutator_unit_tb;
  import bppc_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int PERIOD       = PWM_PERIOD_DEF;
  localparam int SETTLE_CYC   = 8;
  localparam int END_WAIT_CYC = 5000;
  localparam int MAX_REPORTS  = 40;
  localparam int PHASE_ITEMS  = 92;
  localparam longint TIMEOUT_NS = 64'd3_000_000;

  // Register index that maps to no gain; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam longint ESUM_HI = 64'sd2147483647;
  localparam longint ESUM_LO = -64'sd2147483648;
  localparam longint IPROD_LIM = 64'sh4000_0000_0000_0000;

  // Gate tables packed with Hall code 7 in the top slice and code 0 at the bottom.
  localparam logic [47:0] TBL_ON_FWD  = {6'h00, 6'h18, 6'h21, 6'h09, 6'h06, 6'h12, 6'h24, 6'h00};
  localparam logic [47:0] TBL_ON_REV  = {6'h00, 6'h24, 6'h12, 6'h06, 6'h09, 6'h21, 6'h18, 6'h00};
  localparam logic [47:0] TBL_OFF_FWD = {6'h00, 6'h08, 6'h20, 6'h01, 6'h02, 6'h02, 6'h04, 6'h00};
  localparam logic [47:0] TBL_OFF_REV = {6'h00, 6'h04, 6'h02, 6'h02, 6'h01, 6'h01, 6'h08, 6'h00};

  typedef struct {
    kind_e                     kind;
    logic signed [SPEED_W-1:0] target;
    logic signed [SPEED_W-1:0] measured;
    logic                      rev;
    logic [HALL_W-1:0]         hall;
  } motor_cmd_t;

  typedef struct {
    logic [GATE_W-1:0] gate;
    logic [DUTY_W-1:0] duty;
    logic              dir;
  } motor_out_t;

  // Clock, reset and block inputs, all known from time zero.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic kind_i = 1'b0;
  logic signed [SPEED_W-1:0] target_speed_i = '0;
  logic signed [SPEED_W-1:0] measured_speed_i = '0;
  logic reverse_mode_i = 1'b0;
  logic [HALL_W-1:0] hall_code_i = '0;
  logic out_ready_i = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [GAIN_W-1:0] cfg_wdata_i = '0;

  logic in_ready_o;
  logic out_valid_o;
  logic [GATE_W-1:0] gate_bits_o;
  logic [DUTY_W-1:0] duty_o;
  logic direction_o;

  // Stimulus and expectation stores.
  motor_cmd_t pending_cmds[$];
  motor_out_t expected_outputs[$];
  motor_cmd_t cmd_on_bus;

  // Local copy of the controller state and gains.
  logic [GAIN_W-1:0] kp, ki, kd;
  int                pwm_pos;
  logic [DUTY_W-1:0] duty_now;
  logic              dir_now;
  int                err_acc;
  int                err_last;
  logic [GATE_W-1:0] gate_now;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_sent = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_ctrl = 0;
  int n_tick = 0;
  int n_settings = 0;
  int n_errors = 0;

  bldc_pid_pwm_commutator_unit #(
    .PWM_PERIOD(PERIOD)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .target_speed_i  (target_speed_i),
    .measured_speed_i(measured_speed_i),
    .reverse_mode_i  (reverse_mode_i),
    .hall_code_i     (hall_code_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .gate_bits_o     (gate_bits_o),
    .duty_o          (duty_o),
    .direction_o     (direction_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Gate pattern for a direction, PWM phase and Hall code.
  function automatic logic [GATE_W-1:0] commutation_pattern(logic dir, logic phase_on,
                                                            logic [HALL_W-1:0] hall);
    logic [47:0] tbl;
    if (phase_on) begin
      tbl = dir ? TBL_ON_REV : TBL_ON_FWD;
    end else begin
      tbl = dir ? TBL_OFF_REV : TBL_OFF_FWD;
    end
    return tbl[int'(hall) * 6 +: 6];
  endfunction

  function automatic motor_cmd_t make_cmd(kind_e kind, int target, int measured,
                                          logic rev, logic [HALL_W-1:0] hall);
    motor_cmd_t c;
    c.kind = kind;
    c.target = SPEED_W'(target);
    c.measured = SPEED_W'(measured);
    c.rev = rev;
    c.hall = hall;
    return c;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    n_errors++;
    if (n_errors <= MAX_REPORTS) begin
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // Advance the controller by one accepted item and queue the result it produces.
  task automatic predict_motor_step(input motor_cmd_t c);
    int         err;
    longint     acc, iprod, total, mag;
    longint     gp, gi, gd;
    logic       neg;
    motor_out_t res;
    if (c.kind == KIND_TICK) begin
      n_tick++;
      pwm_pos = (pwm_pos + 1 >= PERIOD) ? 0 : pwm_pos + 1;
      // Codes with all sensors equal carry no position, so the gates hold.
      if (c.hall != HALL_NONE && c.hall != HALL_ALL) begin
        gate_now = commutation_pattern(dir_now, pwm_pos <= int'(duty_now), c.hall);
      end
    end else begin
      n_ctrl++;
      gp = longint'(kp);
      gi = longint'(ki);
      gd = longint'(kd);
      err = int'(c.target) - int'(c.measured);
      // The integral saturates at the 32-bit signed limits.
      acc = longint'(err_acc) + err;
      if (acc > ESUM_HI) acc = ESUM_HI;
      if (acc < ESUM_LO) acc = ESUM_LO;
      err_acc = int'(acc);
      iprod = gi * longint'(err_acc);
      if (iprod > IPROD_LIM) iprod = IPROD_LIM;
      if (iprod < -IPROD_LIM) iprod = -IPROD_LIM;
      total = gp * err + gd * (err - err_last) + iprod;
      neg = (total < 0);
      mag = (neg ? -total : total) >>> 16;
      duty_now = (mag > 255) ? DUTY_MAX : mag[7:0];
      dir_now = neg ^ c.rev;
      err_last = err;
    end
    res.gate = gate_now;
    res.duty = duty_now;
    res.dir = dir_now;
    expected_outputs.push_back(res);
  endtask

  // Item driver: holds each item until accepted, with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_motor_step(cmd_on_bus);
        n_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cmd_on_bus = pending_cmds.pop_front();
          in_valid_i <= 1'b1;
          kind_i <= cmd_on_bus.kind;
          target_speed_i <= cmd_on_bus.target;
          measured_speed_i <= cmd_on_bus.measured;
          reverse_mode_i <= cmd_on_bus.rev;
          hall_code_i <= cmd_on_bus.hall;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted result and stalls the output at random.
  always @(posedge clk_i or negedge rst_ni) begin
    motor_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_outputs.size() == 0) begin
          report_mismatch("result with nothing outstanding", gate_bits_o, -1);
        end else begin
          want = expected_outputs.pop_front();
          n_results++;
          if (gate_bits_o !== want.gate) report_mismatch("gate_bits", gate_bits_o, want.gate);
          if (duty_o !== want.duty) report_mismatch("duty", duty_o, want.duty);
          if (direction_o !== want.dir) report_mismatch("direction", direction_o, want.dir);
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_cmd(input motor_cmd_t c);
    pending_cmds.push_back(c);
    n_sent++;
    while (pending_cmds.size() > 2) @(posedge clk_i);
  endtask

  // Wait until every item is taken and every result is back, then let the pipe settle.
  task automatic wait_drained();
    while (n_accepted != n_sent || expected_outputs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      REG_GAIN_P: kp = data;
      REG_GAIN_I: ki = data;
      REG_GAIN_D: kd = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_gains(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                            input logic [GAIN_W-1:0] d);
    write_gain(REG_GAIN_P, p);
    write_gain(REG_GAIN_I, i);
    write_gain(REG_GAIN_D, d);
    n_settings++;
  endtask

  // Mostly ticks with valid Hall codes and updates with nearby speeds,
  // plus full-range speeds and invalid codes as noise.
  task automatic random_cmd(output motor_cmd_t c);
    int t, m;
    c.kind = ($urandom_range(0, 99) < 30) ? KIND_CTRL : KIND_TICK;
    c.target = SPEED_W'($urandom);
    c.measured = SPEED_W'($urandom);
    c.rev = 1'($urandom);
    c.hall = HALL_W'($urandom);
    if (c.kind == KIND_CTRL && $urandom_range(0, 99) < 75) begin
      t = $urandom_range(0, 2047);
      t = t - 1024;
      m = $urandom_range(0, 24);
      m = t + m - 12;
      if (m > 1023) m = 1023;
      if (m < -1024) m = -1024;
      c.target = SPEED_W'(t);
      c.measured = SPEED_W'(m);
    end
    if (c.kind == KIND_TICK && $urandom_range(0, 99) < 85) begin
      c.hall = HALL_W'($urandom_range(1, 6));
    end
  endtask

  // One random phase; partway through the sender holds off until all is back.
  task automatic run_random(input int count);
    motor_cmd_t c;
    for (int k = 0; k < count; k++) begin
      if (k == count / 2) wait_drained();
      random_cmd(c);
      send_cmd(c);
    end
  endtask

  task automatic moderate_gains();
    load_gains($urandom_range(0, 32'h0002_0000), $urandom_range(0, 32'h0000_0800),
               $urandom_range(0, 32'h0001_0000));
  endtask

  // Main sequence.
  initial begin
    int waited;
    kp = GAIN_P_RST;
    ki = GAIN_I_RST;
    kd = GAIN_D_RST;
    pwm_pos = 0;
    duty_now = DUTY_RST;
    dir_now = 1'b0;
    err_acc = 0;
    err_last = 0;
    gate_now = '0;
    n_settings = 1;
    send_idle_pct = 31;
    recv_idle_pct = 63;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: invalid and valid Hall codes, full-scale errors both ways,
    // both reverse settings, saturated duty, then zero duty for the off phase.
    send_cmd(make_cmd(KIND_TICK, 0, 0, 1'b0, HALL_NONE));
    send_cmd(make_cmd(KIND_TICK, 0, 0, 1'b0, HALL_ALL));
    for (int h = 1; h <= 6; h++) send_cmd(make_cmd(KIND_TICK, 0, 0, 1'b0, HALL_W'(h)));
    send_cmd(make_cmd(KIND_CTRL, 1023, -1024, 1'b0, HALL_NONE));
    send_cmd(make_cmd(KIND_CTRL, -1024, 1023, 1'b0, HALL_NONE));
    for (int h = 1; h <= 6; h++) begin
      send_cmd(make_cmd(KIND_TICK, -1024, 1023, 1'b1, HALL_W'(h)));
    end
    send_cmd(make_cmd(KIND_CTRL, -1024, 1023, 1'b1, HALL_ALL));
    send_cmd(make_cmd(KIND_CTRL, 0, 0, 1'b1, HALL_NONE));
    send_cmd(make_cmd(KIND_CTRL, 1023, 1023, 1'b0, HALL_ALL));
    send_cmd(make_cmd(KIND_CTRL, -1024, -1024, 1'b1, HALL_NONE));
    for (int h = 1; h <= 6; h++) begin
      send_cmd(make_cmd(KIND_TICK, 1023, 1023, 1'b0, HALL_W'(h)));
    end
    wait_drained();

    // All gains cleared, and a write to the unused index that must change nothing.
    load_gains('0, '0, '0);
    write_gain(REG_UNUSED, '1);
    run_random(PHASE_ITEMS);
    wait_drained();

    // All gains at full scale.
    load_gains('1, '1, '1);
    run_random(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 63;
    recv_idle_pct = 31;
    moderate_gains();
    write_gain(REG_UNUSED, $urandom);
    run_random(PHASE_ITEMS);
    wait_drained();

    load_gains($urandom, $urandom, $urandom);
    run_random(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    moderate_gains();
    run_random(PHASE_ITEMS);
    wait_drained();

    moderate_gains();
    run_random(PHASE_ITEMS);

    waited = 0;
    while ((n_accepted != n_sent || expected_outputs.size() != 0) && waited < END_WAIT_CYC) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (expected_outputs.size() != 0) begin
      report_mismatch("results never delivered", 0, expected_outputs.size());
    end

    $display("Run covered %0d control updates and %0d PWM ticks under %0d gain settings;",
             n_ctrl, n_tick, n_settings);
    $display("%0d results compared, %0d mismatches.", n_results, n_errors);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog for a block that stops answering.
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d results outstanding.", expected_outputs.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bppc_pkg.sv
hw/rtl/bppc_front.sv
hw/rtl/bppc_queue.sv
hw/rtl/bppc_back.sv
hw/rtl/bldc_pid_pwm_commutator_unit.sv
sim/bldc_pid_pwm_commutator_unit_tb.sv
